/* design/pzb_pkg.sv */
`default_nettype none
package pzb_pkg;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } in_word_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [15:0] out_quat_w;
    logic signed [15:0] out_quat_x;
    logic signed [15:0] out_quat_y;
    logic signed [15:0] out_quat_z;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic signed [31:0] out_vel_z;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAL_DOT,
    ST_CAL_UPD,
    ST_FIN_SQ,
    ST_FIN_CHK,
    ST_POS_DIV,
    ST_NORM,
    ST_SQRT,
    ST_Q_DIV,
    ST_REM_Q,
    ST_REM_M,
    ST_REM_R,
    ST_DONE
  } state_t;

  // one term of a rotation matrix entry: sign * b[ia] * b[ib]
  typedef struct packed {
    logic [1:0] ia;
    logic [1:0] ib;
    logic       neg;
    logic       diag;
  } mat_term_t;

  localparam logic [1:0] STAT_CALIB = 2'd0;
  localparam logic [1:0] STAT_DONE  = 2'd1;
  localparam logic [1:0] STAT_FAIL  = 2'd2;
  localparam logic [1:0] STAT_REMAP = 2'd3;

  localparam logic [11:0] CALIB_RESET = 12'd300;
  localparam logic [30:0] DEGEN_MUL   = 31'd244140625;
  localparam logic [5:0]  DIV_STEPS   = 6'd48;
  localparam logic [47:0] Q_ONE       = 48'd16384;
  localparam logic [63:0] SQRT_TOP    = 64'h4000_0000_0000_0000;
  localparam logic signed [65:0] M_ONE = 66'sd268435456;
  localparam logic signed [65:0] M_LIM = 66'sd536870912;

  // sign of term j in component i of conj(b) * q
  function automatic logic qp_neg(input logic [1:0] i, input logic [1:0] j);
    logic r;
    case ({i, j})
      4'b0101: r = 1'b1;
      4'b0110: r = 1'b1;
      4'b1010: r = 1'b1;
      4'b1011: r = 1'b1;
      4'b1101: r = 1'b1;
      4'b1111: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // index w=0 x=1 y=2 z=3
  function automatic mat_term_t mat_term(input logic [3:0] e, input logic t);
    mat_term_t m;
    case ({e, t})
      5'b0000_0: m = '{ia: 2'd2, ib: 2'd2, neg: 1'b1, diag: 1'b1};
      5'b0000_1: m = '{ia: 2'd3, ib: 2'd3, neg: 1'b1, diag: 1'b1};
      5'b0001_0: m = '{ia: 2'd1, ib: 2'd2, neg: 1'b0, diag: 1'b0};
      5'b0001_1: m = '{ia: 2'd0, ib: 2'd3, neg: 1'b0, diag: 1'b0};
      5'b0010_0: m = '{ia: 2'd1, ib: 2'd3, neg: 1'b0, diag: 1'b0};
      5'b0010_1: m = '{ia: 2'd0, ib: 2'd2, neg: 1'b1, diag: 1'b0};
      5'b0011_0: m = '{ia: 2'd1, ib: 2'd2, neg: 1'b0, diag: 1'b0};
      5'b0011_1: m = '{ia: 2'd0, ib: 2'd3, neg: 1'b1, diag: 1'b0};
      5'b0100_0: m = '{ia: 2'd1, ib: 2'd1, neg: 1'b1, diag: 1'b1};
      5'b0100_1: m = '{ia: 2'd3, ib: 2'd3, neg: 1'b1, diag: 1'b1};
      5'b0101_0: m = '{ia: 2'd2, ib: 2'd3, neg: 1'b0, diag: 1'b0};
      5'b0101_1: m = '{ia: 2'd0, ib: 2'd1, neg: 1'b0, diag: 1'b0};
      5'b0110_0: m = '{ia: 2'd1, ib: 2'd3, neg: 1'b0, diag: 1'b0};
      5'b0110_1: m = '{ia: 2'd0, ib: 2'd2, neg: 1'b0, diag: 1'b0};
      5'b0111_0: m = '{ia: 2'd2, ib: 2'd3, neg: 1'b0, diag: 1'b0};
      5'b0111_1: m = '{ia: 2'd0, ib: 2'd1, neg: 1'b1, diag: 1'b0};
      5'b1000_0: m = '{ia: 2'd1, ib: 2'd1, neg: 1'b1, diag: 1'b1};
      5'b1000_1: m = '{ia: 2'd2, ib: 2'd2, neg: 1'b1, diag: 1'b1};
      default:   m = '{ia: 2'd0, ib: 2'd0, neg: 1'b0, diag: 1'b0};
    endcase
    return m;
  endfunction

  // shift right with rounding to nearest, ties away from zero
  function automatic logic signed [65:0] rnd_shr(input logic signed [65:0] v,
                                                 input int unsigned sh);
    logic [65:0] mag;
    logic [65:0] half;
    logic [65:0] q;
    half = 66'd1 << (sh - 1);
    mag  = v[65] ? 66'(-v) : 66'(v);
    q    = (mag + half) >> sh;
    return v[65] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [15:0] sat_q(input logic signed [65:0] v);
    logic signed [15:0] r;
    if (v > 66'sd16384) r = 16'sd16384;
    else if (v < -66'sd16384) r = -16'sd16384;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat_32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fff_ffff;
    else if (v < -66'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/pose_zero_bias_calibrate_and_remap.sv */
// pose zero-bias calibration and frame remapping
//
// in_word carries one pose frame (position, orientation quaternion, velocity),
// taken when in_valid is high and in_stall low. every frame gives exactly one
// out_word, offered on out_valid and held until a cycle with out_stall low.
// cfg_we/cfg_data write the frame count of the calibration phase (reset 300).
// the first calib_frames frames are summed: status 0 per frame, then status 1
// when the bias is ready, or status 2 when the averaged quaternion degenerates
// and calibration starts over. later frames come out remapped, status 3.
// all arithmetic runs through one 33x31 multiplier with an accumulator, one
// radix-2 divider and one bit-pair square root stage, under a sequencer.
// a remapped frame runs 52 multiply-accumulate terms, and the frame that
// closes calibration adds seven 48-step divisions, up to 30 normalize
// steps and 32 square root steps. in_stall is high while a frame is in work.
// a finished word waits in the output register; the next frame is taken
// meanwhile, and its result waits in the sequencer until the output is free.
// synchronous reset clears the calibration state and the result channel.
`default_nettype none
module pose_zero_bias_calibrate_and_remap #(
  parameter int MAX_CALIB_FRAMES = 4095
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  pzb_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  wire                 out_stall,
  output pzb_pkg::out_word_t  out_word,
  input  wire                 cfg_we,
  input  wire  [11:0]         cfg_data
);

  // sequencer
  pzb_pkg::state_t state_r, state_nxt;
  logic [3:0] grp_r, grp_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       ph_r, ph_nxt;

  // frame in work, register, calibration state
  pzb_pkg::in_word_t in_r, in_nxt;
  logic [11:0] cfg_frames_r;
  logic [11:0] fs_r, fs_nxt;
  logic        bias_r, bias_nxt;
  logic signed [43:0] psum_r [3];
  logic signed [43:0] psum_nxt [3];
  logic signed [27:0] qsum_r [4];
  logic signed [27:0] qsum_nxt [4];

  // shared multiplier and accumulator
  logic signed [32:0] mul_a;
  logic signed [30:0] mul_b;
  logic               term_neg;
  logic [5:0]         nterms;
  logic signed [63:0] prod_r, prod_nxt;
  logic signed [65:0] acc_r, acc_nxt;
  logic signed [65:0] acc_sum;
  logic               mac_wb;

  // normalize, square root and divider
  logic [55:0] s_r, s_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] res_r, res_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic [4:0]  k_r, k_nxt;
  logic [47:0] num_r, num_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [32:0] rem_sh;
  logic        div_ge;
  logic [64:0] sq_sum;

  logic signed [30:0] mat_r [9];
  logic signed [30:0] mat_nxt [9];

  pzb_pkg::out_word_t rslt_r, rslt_nxt;
  pzb_pkg::out_word_t out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  // unpacked views of the frame and the bias
  logic signed [31:0] pin [3];
  logic signed [31:0] vin [3];
  logic signed [15:0] qin [4];
  logic signed [15:0] bq [4];
  logic signed [44:0] dwide [3];
  logic signed [32:0] dif [3];

  logic [1:0]  cnt2, grp2, row_sel;
  logic [3:0]  mat_idx;
  logic [16:0] tgt;
  logic [11:0] fs_inc;
  logic        in_acc;
  pzb_pkg::mat_term_t mt;

  assign cnt2 = cnt_r[1:0];
  assign grp2 = grp_r[1:0];

  always_comb begin
    pin[0] = in_r.pos_x;
    pin[1] = in_r.pos_y;
    pin[2] = in_r.pos_z;
    vin[0] = in_r.vel_x;
    vin[1] = in_r.vel_y;
    vin[2] = in_r.vel_z;
    qin[0] = in_r.quat_w;
    qin[1] = in_r.quat_x;
    qin[2] = in_r.quat_y;
    qin[3] = in_r.quat_z;
    for (int i = 0; i < 4; i++) begin
      bq[i] = qsum_r[i][15:0];
    end
    for (int i = 0; i < 3; i++) begin
      dwide[i] = 45'(pin[i]) - 45'(psum_r[i]);
      dif[i]   = dwide[i][32:0];
    end
  end

  // effective frame count: zero acts as one, capped by the parameter
  always_comb begin
    if (cfg_frames_r == 12'd0) begin
      tgt = 17'd1;
    end else if (17'(cfg_frames_r) > 17'(MAX_CALIB_FRAMES)) begin
      tgt = 17'(MAX_CALIB_FRAMES);
    end else begin
      tgt = 17'(cfg_frames_r);
    end
  end

  assign fs_inc   = fs_r + 12'd1;
  assign in_stall = (state_r != pzb_pkg::ST_IDLE);
  assign in_acc   = in_valid && (state_r == pzb_pkg::ST_IDLE);

  // operand select for the shared multiplier
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    term_neg = 1'b0;
    nterms   = 6'd0;
    row_sel  = (grp_r < 4'd3) ? grp2 : 2'(grp_r - 4'd3);
    mat_idx  = 4'({row_sel, 1'b0}) + 4'(row_sel) + 4'(cnt2);
    mt       = pzb_pkg::mat_term(grp_r, cnt_r[0]);
    case (state_r)
      pzb_pkg::ST_CAL_DOT: begin
        mul_a  = 33'(qsum_r[cnt2]);
        mul_b  = 31'(qin[cnt2]);
        nterms = 6'd4;
      end
      pzb_pkg::ST_FIN_SQ: begin
        mul_a  = 33'(qsum_r[cnt2]);
        mul_b  = 31'(qsum_r[cnt2]);
        nterms = 6'd4;
      end
      pzb_pkg::ST_FIN_CHK: begin
        if (cnt_r == 6'd0) begin
          mul_a = {13'd0, s_r[19:0]};
          mul_b = pzb_pkg::DEGEN_MUL;
        end else begin
          mul_a = {21'd0, fs_r};
          mul_b = {19'd0, fs_r};
        end
      end
      pzb_pkg::ST_REM_Q: begin
        mul_a    = 33'(bq[cnt2]);
        mul_b    = 31'(qin[grp2 ^ cnt2]);
        term_neg = pzb_pkg::qp_neg(grp2, cnt2);
        nterms   = 6'd4;
      end
      pzb_pkg::ST_REM_M: begin
        mul_a    = 33'(bq[mt.ia]);
        mul_b    = 31'(bq[mt.ib]);
        term_neg = mt.neg;
        nterms   = 6'd2;
      end
      pzb_pkg::ST_REM_R: begin
        mul_a  = (grp_r < 4'd3) ? dif[cnt2] : 33'(vin[cnt2]);
        mul_b  = mat_r[mat_idx];
        nterms = 6'd3;
      end
      default: begin
        mul_a = '0;
      end
    endcase
    prod_nxt = 64'(mul_a) * 64'(mul_b);
    acc_sum  = ((cnt_r == 6'd0) ? 66'sd0 : acc_r)
             + (term_neg ? -66'(prod_r) : 66'(prod_r));
    mac_wb   = (ph_r == 1'b0) && (cnt_r == nterms);
    // one restoring divide step and one square root step
    rem_sh   = {rem_r, num_r[47]};
    div_ge   = (rem_sh >= {1'b0, dvs_r});
    sq_sum   = 65'(res_r) + 65'(bit_r);
  end

  // next state and datapath control
  always_comb begin
    logic [43:0] pmag;
    logic [27:0] qmag;
    logic [63:0] mk;
    logic [47:0] qq;
    logic signed [65:0] mv;
    logic signed [15:0] qv;
    logic signed [31:0] rv;

    state_nxt     = state_r;
    grp_nxt       = grp_r;
    cnt_nxt       = cnt_r;
    ph_nxt        = ph_r;
    in_nxt        = in_r;
    fs_nxt        = fs_r;
    bias_nxt      = bias_r;
    psum_nxt      = psum_r;
    qsum_nxt      = qsum_r;
    acc_nxt       = acc_r;
    s_nxt         = s_r;
    x_nxt         = x_r;
    res_nxt       = res_r;
    bit_nxt       = bit_r;
    k_nxt         = k_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    mat_nxt       = mat_r;
    rslt_nxt      = rslt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    pmag = psum_r[grp2][43] ? 44'(-psum_r[grp2]) : 44'(psum_r[grp2]);
    qmag = qsum_r[grp2][27] ? 28'(-qsum_r[grp2]) : 28'(qsum_r[grp2]);
    mk   = 64'(qmag) << k_r;
    qq   = (num_r > pzb_pkg::Q_ONE) ? pzb_pkg::Q_ONE : num_r;
    mv   = (mt.diag ? pzb_pkg::M_ONE : 66'sd0) + (acc_r <<< 1);
    qv   = pzb_pkg::sat_q(pzb_pkg::rnd_shr(acc_r, 14));
    rv   = pzb_pkg::sat_32(pzb_pkg::rnd_shr(acc_r, 28));

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      pzb_pkg::ST_IDLE: begin
        if (in_acc) begin
          in_nxt    = in_word;
          rslt_nxt  = '0;
          grp_nxt   = 4'd0;
          cnt_nxt   = 6'd0;
          ph_nxt    = 1'b0;
          state_nxt = bias_r ? pzb_pkg::ST_REM_Q : pzb_pkg::ST_CAL_DOT;
        end
      end

      pzb_pkg::ST_CAL_DOT, pzb_pkg::ST_FIN_SQ, pzb_pkg::ST_REM_Q,
      pzb_pkg::ST_REM_M, pzb_pkg::ST_REM_R: begin
        if (!mac_wb) begin
          if (ph_r) begin
            acc_nxt = acc_sum;
            cnt_nxt = cnt_r + 6'd1;
            ph_nxt  = 1'b0;
          end else begin
            ph_nxt = 1'b1;
          end
        end else begin
          cnt_nxt = 6'd0;
          case (state_r)
            pzb_pkg::ST_CAL_DOT: begin
              state_nxt = pzb_pkg::ST_CAL_UPD;
            end
            pzb_pkg::ST_FIN_SQ: begin
              s_nxt     = acc_r[55:0];
              x_nxt     = 64'(acc_r[55:0]);
              k_nxt     = 5'd0;
              state_nxt = pzb_pkg::ST_FIN_CHK;
            end
            pzb_pkg::ST_REM_Q: begin
              case (grp2)
                2'd0:    rslt_nxt.out_quat_w = qv;
                2'd1:    rslt_nxt.out_quat_x = qv;
                2'd2:    rslt_nxt.out_quat_y = qv;
                default: rslt_nxt.out_quat_z = qv;
              endcase
              grp_nxt = grp_r + 4'd1;
              if (grp_r == 4'd3) begin
                grp_nxt   = 4'd0;
                state_nxt = pzb_pkg::ST_REM_M;
              end
            end
            pzb_pkg::ST_REM_M: begin
              if (mv > pzb_pkg::M_LIM) mat_nxt[grp_r] = 31'(pzb_pkg::M_LIM);
              else if (mv < -pzb_pkg::M_LIM) mat_nxt[grp_r] = 31'(-pzb_pkg::M_LIM);
              else mat_nxt[grp_r] = mv[30:0];
              grp_nxt = grp_r + 4'd1;
              if (grp_r == 4'd8) begin
                grp_nxt   = 4'd0;
                state_nxt = pzb_pkg::ST_REM_R;
              end
            end
            default: begin
              case (grp_r)
                4'd0:    rslt_nxt.out_pos_x = rv;
                4'd1:    rslt_nxt.out_pos_y = rv;
                4'd2:    rslt_nxt.out_pos_z = rv;
                4'd3:    rslt_nxt.out_vel_x = rv;
                4'd4:    rslt_nxt.out_vel_y = rv;
                default: rslt_nxt.out_vel_z = rv;
              endcase
              grp_nxt = grp_r + 4'd1;
              if (grp_r == 4'd5) begin
                rslt_nxt.status = pzb_pkg::STAT_REMAP;
                state_nxt       = pzb_pkg::ST_DONE;
              end
            end
          endcase
        end
      end

      pzb_pkg::ST_CAL_UPD: begin
        fs_nxt = fs_inc;
        for (int i = 0; i < 4; i++) begin
          if (fs_r == 12'd0) begin
            qsum_nxt[i] = 28'(qin[i]);
          end else begin
            qsum_nxt[i] = qsum_r[i] + (acc_r[65] ? -28'(qin[i]) : 28'(qin[i]));
          end
        end
        for (int i = 0; i < 3; i++) begin
          psum_nxt[i] = psum_r[i] + 44'(pin[i]);
        end
        cnt_nxt = 6'd0;
        ph_nxt  = 1'b0;
        if (17'(fs_inc) < tgt) begin
          rslt_nxt.status = pzb_pkg::STAT_CALIB;
          state_nxt       = pzb_pkg::ST_DONE;
        end else begin
          state_nxt = pzb_pkg::ST_FIN_SQ;
        end
      end

      pzb_pkg::ST_FIN_CHK: begin
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else if (cnt_r == 6'd0) begin
          acc_nxt = 66'(prod_r);
          cnt_nxt = 6'd1;
          ph_nxt  = 1'b0;
        end else begin
          cnt_nxt = 6'd0;
          ph_nxt  = 1'b0;
          grp_nxt = 4'd0;
          // average norm below 1e-6: drop everything and start over
          if ((s_r[55:20] == 36'd0) && (acc_r < (66'(prod_r) <<< 16))) begin
            fs_nxt   = 12'd0;
            bias_nxt = 1'b0;
            for (int i = 0; i < 3; i++) psum_nxt[i] = '0;
            for (int i = 0; i < 4; i++) qsum_nxt[i] = '0;
            rslt_nxt.status = pzb_pkg::STAT_FAIL;
            state_nxt       = pzb_pkg::ST_DONE;
          end else begin
            state_nxt = pzb_pkg::ST_POS_DIV;
          end
        end
      end

      pzb_pkg::ST_POS_DIV, pzb_pkg::ST_Q_DIV: begin
        if (!ph_r) begin
          rem_nxt = '0;
          cnt_nxt = 6'd0;
          ph_nxt  = 1'b1;
          if (state_r == pzb_pkg::ST_POS_DIV) begin
            num_nxt = 48'({pmag, 1'b0}) + 48'(fs_r);
            dvs_nxt = {19'd0, fs_r, 1'b0};
          end else begin
            num_nxt = 48'((mk << 15) + 64'(res_r[31:0]));
            dvs_nxt = {res_r[30:0], 1'b0};
          end
        end else if (cnt_r != pzb_pkg::DIV_STEPS) begin
          rem_nxt = div_ge ? 32'(rem_sh - {1'b0, dvs_r}) : rem_sh[31:0];
          num_nxt = {num_r[46:0], div_ge};
          cnt_nxt = cnt_r + 6'd1;
        end else begin
          cnt_nxt = 6'd0;
          ph_nxt  = 1'b0;
          grp_nxt = grp_r + 4'd1;
          if (state_r == pzb_pkg::ST_POS_DIV) begin
            psum_nxt[grp2] = psum_r[grp2][43] ? -44'(num_r) : 44'(num_r);
            if (grp_r == 4'd2) begin
              grp_nxt   = 4'd0;
              state_nxt = pzb_pkg::ST_NORM;
            end
          end else begin
            qsum_nxt[grp2] = qsum_r[grp2][27] ? -28'(qq) : 28'(qq);
            if (grp_r == 4'd3) begin
              grp_nxt         = 4'd0;
              bias_nxt        = 1'b1;
              rslt_nxt.status = pzb_pkg::STAT_DONE;
              state_nxt       = pzb_pkg::ST_DONE;
            end
          end
        end
      end

      pzb_pkg::ST_NORM: begin
        if (x_r[63:60] == 4'd0) begin
          x_nxt = {x_r[61:0], 2'b00};
          k_nxt = k_r + 5'd1;
        end else begin
          res_nxt   = '0;
          bit_nxt   = pzb_pkg::SQRT_TOP;
          state_nxt = pzb_pkg::ST_SQRT;
        end
      end

      pzb_pkg::ST_SQRT: begin
        if (65'(x_r) >= sq_sum) begin
          x_nxt   = x_r - sq_sum[63:0];
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) begin
          grp_nxt   = 4'd0;
          cnt_nxt   = 6'd0;
          ph_nxt    = 1'b0;
          state_nxt = pzb_pkg::ST_Q_DIV;
        end
      end

      pzb_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = rslt_r;
          out_valid_nxt = 1'b1;
          state_nxt     = pzb_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = pzb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pzb_pkg::ST_IDLE;
      grp_r        <= 4'd0;
      cnt_r        <= 6'd0;
      ph_r         <= 1'b0;
      cfg_frames_r <= pzb_pkg::CALIB_RESET;
      fs_r         <= 12'd0;
      bias_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < 3; i++) psum_r[i] <= '0;
      for (int i = 0; i < 4; i++) qsum_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      grp_r       <= grp_nxt;
      cnt_r       <= cnt_nxt;
      ph_r        <= ph_nxt;
      fs_r        <= fs_nxt;
      bias_r      <= bias_nxt;
      out_valid_r <= out_valid_nxt;
      psum_r      <= psum_nxt;
      qsum_r      <= qsum_nxt;
      if (cfg_we) begin
        cfg_frames_r <= cfg_data;
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    in_r   <= in_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    s_r    <= s_nxt;
    x_r    <= x_nxt;
    res_r  <= res_nxt;
    bit_r  <= bit_nxt;
    k_r    <= k_nxt;
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    mat_r  <= mat_nxt;
    rslt_r <= rslt_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // a taken frame always puts the sequencer to work
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != pzb_pkg::ST_IDLE))
    else $error("sequencer idle after taking a frame");

  // a ready bias implies at least one frame was averaged
  a_bias_has_frames: assert property (@(posedge clk) disable iff (!rst_n)
    bias_r |-> (fs_r != 12'd0))
    else $error("bias ready with no frames counted");

  // bias becomes ready only together with the calibration-done word
  a_bias_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(bias_r) |-> (state_r == pzb_pkg::ST_DONE)
                      && (rslt_r.status == pzb_pkg::STAT_DONE))
    else $error("bias ready without calibration done word");

  // calibration words carry zero payload
  a_calib_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status != pzb_pkg::STAT_REMAP)) |->
      ((out_r.out_pos_x == 32'sd0) && (out_r.out_quat_w == 16'sd0)
       && (out_r.out_vel_z == 32'sd0)))
    else $error("nonzero payload on calibration word");

  // square root walks one bit pair at a time
  a_sqrt_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pzb_pkg::ST_SQRT) |-> $onehot(bit_r))
    else $error("square root bit not one-hot");

endmodule
`default_nettype wire
